[rtl/csw_pkg.sv]
`timescale 1ns / 1ps
package csw_pkg;

	localparam int COUNT_W = 16;
	localparam int ID_W = 16;
	localparam int KIND_W = 2;
	localparam int STATUS_W = 3;
	localparam int MAX_WAITERS_DEF = 16;

	localparam logic [KIND_W-1:0] KIND_TRY = 2'd0;
	localparam logic [KIND_W-1:0] KIND_WAIT = 2'd1;
	localparam logic [KIND_W-1:0] KIND_INC = 2'd2;
	localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;

	localparam logic [STATUS_W-1:0] ST_GRANTED = 3'd0;
	localparam logic [STATUS_W-1:0] ST_REFUSED = 3'd1;
	localparam logic [STATUS_W-1:0] ST_QUEUED = 3'd2;
	localparam logic [STATUS_W-1:0] ST_FULL = 3'd3;
	localparam logic [STATUS_W-1:0] ST_WAKE = 3'd4;
	localparam logic [STATUS_W-1:0] ST_INCREMENTED = 3'd5;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [ID_W-1:0]   id;
	} req_t;

endpackage

[rtl/csw_ram.sv]
`timescale 1ns / 1ps
module csw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/csw_front.sv]
`timescale 1ns / 1ps
module csw_front
	import csw_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [KIND_W-1:0] kind,
	input  logic [ID_W-1:0]   requester_id,
	output logic              busy,
	output logic              req_valid,
	output req_t              req,
	input  logic              req_pop
);

	req_t       buf_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       push;

	assign busy = (fill_q == 2'd2);
	assign req_valid = (fill_q != 2'd0);
	assign req = buf_q[rd_ptr_q];

	// drop the unused kind here
	assign push = start && !busy && (kind != KIND_NONE);

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= '{kind: kind, id: requester_id};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (req_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, req_pop})
				2'b10: fill_q <= fill_q + 2'd1;
				2'b01: fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

[rtl/csw_back.sv]
`timescale 1ns / 1ps
module csw_back
	import csw_pkg::*;
#(
	parameter int MAX_WAITERS = MAX_WAITERS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	input  logic [COUNT_W-1:0]  cfg_data,
	input  logic                req_valid,
	input  req_t                req,
	output logic                req_pop,
	output logic                idle,
	output logic                strobe,
	output logic [STATUS_W-1:0] status,
	output logic [ID_W-1:0]     wake_id,
	output logic                last,
	output logic [COUNT_W-1:0]  count_now
);

	localparam int IW = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
	localparam int TW = $clog2(MAX_WAITERS + 1);
	localparam logic [TW-1:0] TOTAL_MAX = TW'(MAX_WAITERS);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_WAKE = 1'b1;

	logic                state_q;
	logic [COUNT_W-1:0]  count_q;
	logic [TW-1:0]       total_q;
	logic [IW-1:0]       idx_q;
	logic                strobe_q;
	logic [STATUS_W-1:0] status_q;
	logic [ID_W-1:0]     wake_id_q;
	logic                last_q;
	logic [COUNT_W-1:0]  count_now_q;

	logic                ram_we;
	logic [IW-1:0]       ram_raddr;
	logic [ID_W-1:0]     ram_rdata;
	logic                wake_last;
	logic                has_unit;

	assign req_pop = req_valid && (state_q == S_IDLE);
	assign idle = !req_valid && (state_q == S_IDLE);
	assign has_unit = (count_q != '0);
	assign wake_last = (TW'(idx_q) == TW'(total_q - 1'b1));

	assign ram_we = req_pop && (req.kind == KIND_WAIT) && !has_unit && (total_q < TOTAL_MAX);
	assign ram_raddr = (state_q == S_WAKE) ? IW'(idx_q + 1'b1) : '0;

	csw_ram #(
		.WIDTH(ID_W),
		.DEPTH(MAX_WAITERS)
	) u_waiters (
		.clk  (clk),
		.we   (ram_we),
		.waddr(total_q[IW-1:0]),
		.wdata(req.id),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			total_q <= '0;
			idx_q <= '0;
			strobe_q <= 1'b0;
		end else if (cfg_valid) begin
			count_q <= cfg_data;
			total_q <= '0;
			state_q <= S_IDLE;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (req_pop) begin
						case (req.kind)
							KIND_TRY, KIND_WAIT: begin
								strobe_q <= 1'b1;
								if (has_unit) begin
									count_q <= count_q - 1'b1;
								end else if (req.kind == KIND_WAIT && total_q < TOTAL_MAX) begin
									total_q <= total_q + 1'b1;
								end
							end
							KIND_INC: begin
								if (count_q != COUNT_MAX) begin
									count_q <= count_q + 1'b1;
								end
								if (total_q == '0) begin
									strobe_q <= 1'b1;
								end else begin
									state_q <= S_WAKE;
									idx_q <= '0;
								end
							end
							default: begin
								strobe_q <= 1'b0;
							end
						endcase
					end
				end
				S_WAKE: begin
					strobe_q <= 1'b1;
					idx_q <= IW'(idx_q + 1'b1);
					if (wake_last) begin
						total_q <= '0;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_WAKE) begin
			status_q <= ST_WAKE;
			wake_id_q <= ram_rdata;
			last_q <= wake_last;
			count_now_q <= count_q;
		end else begin
			wake_id_q <= '0;
			last_q <= 1'b1;
			case (req.kind)
				KIND_INC: begin
					status_q <= ST_INCREMENTED;
					count_now_q <= (count_q != COUNT_MAX) ? count_q + 1'b1 : count_q;
				end
				KIND_WAIT: begin
					status_q <= has_unit ? ST_GRANTED :
						((total_q < TOTAL_MAX) ? ST_QUEUED : ST_FULL);
					count_now_q <= has_unit ? count_q - 1'b1 : count_q;
				end
				default: begin
					status_q <= has_unit ? ST_GRANTED : ST_REFUSED;
					count_now_q <= has_unit ? count_q - 1'b1 : count_q;
				end
			endcase
		end
	end

	assign strobe = strobe_q;
	assign status = status_q;
	assign wake_id = wake_id_q;
	assign last = last_q;
	assign count_now = count_now_q;

endmodule

[rtl/counting_semaphore_with_waiters.sv]
`timescale 1ns / 1ps
// Counting semaphore with a waiter list. A request is taken when start is high and
// busy is low; busy rises only when the two-entry request queue is full. Try and wait
// requests produce one result, in the cycle after they reach the execution stage. An
// increment produces one acknowledgment, or one wake result per stored waiter at one
// per cycle, paced by the single read port of the waiter RAM. Results appear for exactly
// one cycle, marked by strobe, and cannot be stalled. The initial count is written
// through cfg_valid/cfg_ready, which is ready only while no request is queued or
// executing; a write also empties the waiter list.
module counting_semaphore_with_waiters
	import csw_pkg::*;
#(
	parameter int MAX_WAITERS = MAX_WAITERS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [KIND_W-1:0]   kind,
	input  logic [ID_W-1:0]     requester_id,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [COUNT_W-1:0]  cfg_data,
	output logic                strobe,
	output logic [STATUS_W-1:0] status,
	output logic [ID_W-1:0]     wake_id,
	output logic                last,
	output logic [COUNT_W-1:0]  count_now
);

	logic req_valid;
	req_t req;
	logic req_pop;
	logic back_idle;

	csw_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.kind        (kind),
		.requester_id(requester_id),
		.busy        (busy),
		.req_valid   (req_valid),
		.req         (req),
		.req_pop     (req_pop)
	);

	csw_back #(
		.MAX_WAITERS(MAX_WAITERS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.req_valid(req_valid),
		.req      (req),
		.req_pop  (req_pop),
		.idle     (back_idle),
		.strobe   (strobe),
		.status   (status),
		.wake_id  (wake_id),
		.last     (last),
		.count_now(count_now)
	);

	assign cfg_ready = back_idle;

	a_busy_not_idle: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !cfg_ready)
		else $error("queue full while reported idle");

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && status != ST_WAKE) |-> last)
		else $error("single result without last");

	a_no_id: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && status != ST_WAKE) |-> (wake_id == '0))
		else $error("wake id on non-wake result");

	a_wake_run: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && status == ST_WAKE && !last) |=> (strobe && status == ST_WAKE))
		else $error("wake run broken");

endmodule
